FILE: src/rect_placement_with_overlap_table_defines.svh
// Assertion macros shared by the rectangle placement RTL.
`ifndef RECT_PLACEMENT_WITH_OVERLAP_TABLE_DEFINES_SVH
`define RECT_PLACEMENT_WITH_OVERLAP_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPOT_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPOT_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/rpot_pkg.sv
// Types, codes and constants for the rectangle placement block.
`default_nettype none

package rpot_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [7:0] SCREEN_ROWS_RST = 8'd24;
  localparam logic [7:0] SCREEN_COLS_RST = 8'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_ROWS = 1'b0,
    CFG_SCREEN_COLS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_PLACE   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SIDE_RIGHT = 2'd0,
    SIDE_LEFT  = 2'd1
  } side_t;

  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_NONE     = 2'd1,
    ST_RELEASED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAR,
    S_SCAN,
    S_LAST,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] height;
    logic [7:0] width;
  } rect_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } tbl_ctl_t;

endpackage

`default_nettype wire

FILE: src/rpot_slot_table.sv
// Slot table: rectangle memory with registered reads and a valid bit per slot.
`default_nettype none

module rpot_slot_table #(
  parameter int SLOTS = rpot_pkg::SLOTS_DEF,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  rpot_pkg::tbl_ctl_t ctl,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [IDX_W-1:0] wr_addr,
  input  rpot_pkg::rect_t  wr_data,
  output rpot_pkg::rect_t  rd_data,
  output logic             rd_valid
);
  import rpot_pkg::*;

  rect_t            mem [SLOTS];
  logic [SLOTS-1:0] valid;
  logic             valid_q;
  logic             en_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      en_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end else if (ctl.clr) begin
        valid[wr_addr] <= 1'b0;
      end
      en_q <= ctl.rd_en;
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_valid = en_q & valid_q;

endmodule

`default_nettype wire

FILE: src/rect_placement_with_overlap_table.sv
// Top level of the rectangle placement block with its occupancy table.
//
//   channel  direction  handshake             contents
//   in       to block   in_valid / in_stall   op, slots, kind, side, size
//   out      from block out_valid / out_stall status, pos_row, pos_col
//   cfg      to block   cfg_we                cfg_index, cfg_data
//
// A release goes from acceptance straight to the response state. A centered
// place scans every slot once; a beside place first reads the parent slot and
// scans for one candidate, then again for a second if the first is refused,
// on the single table read port that checks one slot per cycle.
// Reset clears the valid bits of all slots and loads the screen size 24 x 80.
// A new item is taken only when the block is idle; a held result stalls it.
`default_nettype none

`include "rect_placement_with_overlap_table_defines.svh"

module rect_placement_with_overlap_table #(
  parameter int SLOTS = rpot_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [3:0]                     surface_slot,
  input  logic                           centered_kind,
  input  logic                           has_parent,
  input  logic [3:0]                     parent_slot,
  input  logic [1:0]                     side,
  input  logic [7:0]                     req_rows,
  input  logic [7:0]                     req_cols,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [7:0]                     pos_row,
  output logic [7:0]                     pos_col,
  input  logic                           cfg_we,
  input  logic [rpot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpot_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpot_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t             state;
  state_t             state_next;
  logic [7:0]         screen_rows;
  logic [7:0]         screen_cols;
  logic [IDX_W-1:0]   surf_q;
  logic [7:0]         h_q;
  logic [7:0]         w_q;
  logic [1:0]         side_q;
  logic               par_ok_q;
  logic signed [9:0]  cand_row;
  logic signed [9:0]  cand_col;
  logic signed [10:0] cand_bot;
  logic signed [10:0] cand_rgt;
  logic signed [9:0]  alt_col;
  logic               have_alt;
  logic               hit;
  logic [IDX_W-1:0]   scan_cnt;
  status_t            res_status;
  logic [7:0]         res_row;
  logic [7:0]         res_col;

  tbl_ctl_t           tbl_ctl;
  logic [IDX_W-1:0]   tbl_rd_addr;
  logic [IDX_W-1:0]   tbl_wr_addr;
  rect_t              tbl_wr_data;
  rect_t              tbl_rd_data;
  logic               tbl_rd_valid;

  logic               accept;
  logic               surf_ok;
  logic               par_ok;
  logic               use_center;
  logic signed [9:0]  diff_r;
  logic signed [9:0]  diff_c;
  logic signed [9:0]  ctr_r;
  logic signed [9:0]  ctr_c;
  logic signed [9:0]  right_col;
  logic signed [9:0]  left_col;
  logic signed [10:0] ent_row;
  logic signed [10:0] ent_col;
  logic signed [10:0] ent_bot;
  logic signed [10:0] ent_rgt;
  logic               touch;
  logic               hit_now;
  logic               cand_fit;
  logic               place_ok;
  logic               out_free;

  rpot_slot_table #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tbl_ctl),
    .rd_addr (tbl_rd_addr),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_data (tbl_rd_data),
    .rd_valid(tbl_rd_valid)
  );

  assign accept = in_valid && !in_stall;
  assign surf_ok = int'(surface_slot) < SLOTS;
  assign par_ok = int'(parent_slot) < SLOTS;
  assign use_center = centered_kind || !has_parent;
  assign out_free = !out_valid || !out_stall;

  // Center offsets, halved with truncation toward zero.
  assign diff_r = $signed({2'b00, screen_rows}) - $signed({2'b00, req_rows});
  assign diff_c = $signed({2'b00, screen_cols}) - $signed({2'b00, req_cols});
  assign ctr_r = diff_r[9] ? ((diff_r + 10'sd1) >>> 1) : (diff_r >>> 1);
  assign ctr_c = diff_c[9] ? ((diff_c + 10'sd1) >>> 1) : (diff_c >>> 1);

  assign right_col = $signed({2'b00, tbl_rd_data.col}) + $signed({2'b00, tbl_rd_data.width});
  assign left_col = $signed({2'b00, tbl_rd_data.col}) - $signed({2'b00, w_q});

  assign ent_row = $signed({3'b000, tbl_rd_data.row});
  assign ent_col = $signed({3'b000, tbl_rd_data.col});
  assign ent_bot = ent_row + $signed({3'b000, tbl_rd_data.height}) - 11'sd1;
  assign ent_rgt = ent_col + $signed({3'b000, tbl_rd_data.width}) - 11'sd1;

  assign touch = tbl_rd_valid &&
                 !((cand_rgt < ent_col) || (ent_rgt < 11'(cand_col)) ||
                   (cand_bot < ent_row) || (ent_bot < 11'(cand_row)));
  assign hit_now = hit || touch;

  assign cand_fit = !cand_row[9] && !cand_col[9] && (h_q != 8'd0) && (w_q != 8'd0) &&
                    (cand_bot < $signed({3'b000, screen_rows})) &&
                    (cand_rgt < $signed({3'b000, screen_cols}));
  assign place_ok = cand_fit && !hit_now;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_RELEASE || !surf_ok) begin
            state_next = S_RESP;
          end else if (use_center) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_PAR;
          end
        end
      end
      S_PAR: begin
        state_next = (par_ok_q && tbl_rd_valid) ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        if (scan_cnt == IDX_W'(SLOTS - 1)) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        if (place_ok || !have_alt) begin
          state_next = S_RESP;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    tbl_ctl = '0;
    tbl_rd_addr = IDX_W'(parent_slot);
    tbl_wr_addr = surf_q;
    tbl_wr_data = {cand_row[7:0], cand_col[7:0], h_q, w_q};
    case (state)
      S_IDLE: begin
        tbl_wr_addr = IDX_W'(surface_slot);
        tbl_ctl.rd_en = in_valid && op == OP_PLACE && surf_ok && !use_center;
        tbl_ctl.clr = in_valid && op == OP_RELEASE && surf_ok;
      end
      S_SCAN: begin
        tbl_rd_addr = scan_cnt;
        tbl_ctl.rd_en = 1'b1;
      end
      S_LAST: begin
        tbl_ctl.wr_en = place_ok;
      end
      default: begin
        tbl_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      screen_rows <= SCREEN_ROWS_RST;
      screen_cols <= SCREEN_COLS_RST;
      out_valid <= 1'b0;
      have_alt <= 1'b0;
      hit <= 1'b0;
      scan_cnt <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_ROWS: screen_rows <= cfg_data;
          CFG_SCREEN_COLS: screen_cols <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            surf_q <= IDX_W'(surface_slot);
            h_q <= req_rows;
            w_q <= req_cols;
            side_q <= side;
            par_ok_q <= par_ok;
            res_status <= (op == OP_RELEASE) ? ST_RELEASED : ST_NONE;
            res_row <= 8'd0;
            res_col <= 8'd0;
            cand_row <= ctr_r;
            cand_col <= ctr_c;
            cand_bot <= 11'(ctr_r) + $signed({3'b000, req_rows}) - 11'sd1;
            cand_rgt <= 11'(ctr_c) + $signed({3'b000, req_cols}) - 11'sd1;
            have_alt <= 1'b0;
            hit <= 1'b0;
            scan_cnt <= '0;
          end
        end
        S_PAR: begin
          cand_row <= $signed({2'b00, tbl_rd_data.row});
          cand_bot <= $signed({3'b000, tbl_rd_data.row}) + $signed({3'b000, h_q}) - 11'sd1;
          if (side_q == SIDE_LEFT) begin
            cand_col <= left_col;
            cand_rgt <= 11'(left_col) + $signed({3'b000, w_q}) - 11'sd1;
            alt_col <= right_col;
          end else begin
            cand_col <= right_col;
            cand_rgt <= 11'(right_col) + $signed({3'b000, w_q}) - 11'sd1;
            alt_col <= left_col;
          end
          have_alt <= (side_q == SIDE_RIGHT) || (side_q == SIDE_LEFT);
        end
        S_SCAN: begin
          hit <= hit_now;
          scan_cnt <= scan_cnt + 1'b1;
        end
        S_LAST: begin
          if (place_ok) begin
            res_status <= ST_PLACED;
            res_row <= cand_row[7:0];
            res_col <= cand_col[7:0];
          end else if (have_alt) begin
            cand_col <= alt_col;
            cand_rgt <= 11'(alt_col) + $signed({3'b000, w_q}) - 11'sd1;
            have_alt <= 1'b0;
            hit <= 1'b0;
            scan_cnt <= '0;
          end
        end
        S_RESP: begin
          if (out_free) begin
            status <= res_status;
            pos_row <= res_row;
            pos_col <= res_col;
          end
        end
        default: ;
      endcase
    end
  end

  `RPOT_ASSERT_IMPL(a_write_fits, clk, rst, tbl_ctl.wr_en, cand_fit && !hit_now && state == S_LAST, "table written with a candidate that is off screen or overlaps")
  `RPOT_ASSERT_IMPL(a_pos_zero, clk, rst, out_valid && status != ST_PLACED, pos_row == 8'd0 && pos_col == 8'd0, "position is not zero on a result that is not placed")
  `RPOT_ASSERT_NEXT(a_leave_idle, clk, rst, accept, state != S_IDLE, "accepted item did not start work")
  `RPOT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(pos_row) && $stable(pos_col), "stalled result changed")

endmodule

`default_nettype wire
